>>> sv/itt_pkg.sv
package itt_pkg;

	// parse modes
	typedef enum logic [2:0] {
		M_SKIP    = 3'd0,
		M_COMMENT = 3'd1,
		M_SECTION = 3'd2,
		M_KEYNAME = 3'd3,
		M_KEYGAP  = 3'd4,
		M_VLEAD   = 3'd5,
		M_VALUE   = 3'd6,
		M_DRAIN   = 3'd7
	} mode_t;

	// record kinds
	typedef enum logic [1:0] {
		KIND_SECTION = 2'd0,
		KIND_KEY     = 2'd1,
		KIND_END_OK  = 2'd2,
		KIND_END_ERR = 2'd3
	} kind_t;

	typedef struct packed {
		kind_t       kind;
		logic [15:0] index;
		logic [15:0] name_start;
		logic [15:0] name_end;
		logic [15:0] value_start;
		logic [15:0] value_end;
		logic        final_flag;
	} rec_t;

	localparam logic [7:0] CH_NUL       = 8'h00;
	localparam logic [7:0] CH_SEMICOLON = 8'h3B;
	localparam logic [7:0] CH_LBRACKET  = 8'h5B;
	localparam logic [7:0] CH_RBRACKET  = 8'h5D;
	localparam logic [7:0] CH_EQUALS    = 8'h3D;
	localparam logic [7:0] CH_LF        = 8'h0A;
	localparam logic [7:0] CH_CR        = 8'h0D;
	localparam logic [7:0] CH_SPACE     = 8'h20;
	localparam logic [7:0] CH_TAB       = 8'h09;

	// space, tab, lf, vt, ff, cr
	function automatic logic is_space(input logic [7:0] b);
		return (b == CH_SPACE) || ((b >= CH_TAB) && (b <= CH_CR));
	endfunction

	function automatic logic is_newline(input logic [7:0] b);
		return (b == CH_LF) || (b == CH_CR);
	endfunction

endpackage

>>> sv/itt_step.sv
module itt_step #(
	parameter int OFFSET_BITS = 16
) (
	input  itt_pkg::mode_t           mode,
	input  logic [OFFSET_BITS-1:0]   pos,
	input  logic                     section_seen,
	input  logic [15:0]              entry_count,
	input  logic [OFFSET_BITS-1:0]   tok_name_start,
	input  logic [OFFSET_BITS-1:0]   tok_name_end,
	input  logic [OFFSET_BITS-1:0]   tok_value_start,
	input  logic [OFFSET_BITS-1:0]   last_nonspace,
	input  logic [7:0]               text_byte,
	input  logic                     last_byte,
	output itt_pkg::mode_t           mode_nxt,
	output logic [OFFSET_BITS-1:0]   pos_nxt,
	output logic                     section_seen_nxt,
	output logic [15:0]              entry_count_nxt,
	output logic [OFFSET_BITS-1:0]   tok_name_start_nxt,
	output logic [OFFSET_BITS-1:0]   tok_name_end_nxt,
	output logic [OFFSET_BITS-1:0]   tok_value_start_nxt,
	output logic [OFFSET_BITS-1:0]   last_nonspace_nxt,
	output logic                     emit,
	output itt_pkg::rec_t            rec
);
	import itt_pkg::*;

	localparam logic [OFFSET_BITS-1:0] POS_ONE = {{(OFFSET_BITS-1){1'b0}}, 1'b1};

	logic                   term;
	logic                   err;
	logic                   n1;
	mode_t                  m1;
	logic [OFFSET_BITS-1:0] pos1;
	logic [OFFSET_BITS-1:0] tns1;
	logic [OFFSET_BITS-1:0] tne1;
	logic [OFFSET_BITS-1:0] tvs1;
	logic [OFFSET_BITS-1:0] lnp1;
	logic                   ss1;
	logic [15:0]            cnt_inc;
	kind_t                  rk;
	logic [15:0]            ridx;
	logic [OFFSET_BITS-1:0] rns;
	logic [OFFSET_BITS-1:0] rne;
	logic [OFFSET_BITS-1:0] rvs;
	logic [OFFSET_BITS-1:0] rve;
	logic                   rfin;
	logic                   clr;

	assign term    = (text_byte == CH_NUL) || last_byte;
	assign cnt_inc = entry_count + 16'd1;

	// byte handling and in-text records
	always_comb begin
		m1   = mode;
		pos1 = pos;
		tns1 = tok_name_start;
		tne1 = tok_name_end;
		tvs1 = tok_value_start;
		lnp1 = last_nonspace;
		ss1  = section_seen;
		n1   = 1'b0;
		err  = 1'b0;
		rk   = KIND_SECTION;
		rns  = '0;
		rne  = '0;
		rvs  = '0;
		rve  = '0;
		if (text_byte != CH_NUL) begin
			pos1 = pos + POS_ONE;
			case (mode)
				M_SKIP: begin
					if (is_space(text_byte)) begin
						m1 = M_SKIP;
					end else if (text_byte == CH_SEMICOLON) begin
						m1 = M_COMMENT;
					end else if (text_byte == CH_LBRACKET) begin
						tns1 = pos + POS_ONE;
						m1   = M_SECTION;
					end else if (!section_seen) begin
						err = 1'b1;
					end else begin
						tns1 = pos;
						if (text_byte == CH_EQUALS) begin
							tne1 = pos;
							m1   = M_VLEAD;
						end else begin
							m1 = M_KEYNAME;
						end
					end
				end
				M_COMMENT: begin
					if (is_newline(text_byte)) m1 = M_SKIP;
				end
				M_SECTION: begin
					if (text_byte == CH_RBRACKET) begin
						rk  = KIND_SECTION;
						rns = tok_name_start;
						rne = pos;
						ss1 = 1'b1;
						m1  = M_SKIP;
						n1  = 1'b1;
					end
				end
				M_KEYNAME: begin
					if (text_byte == CH_EQUALS) begin
						tne1 = pos;
						m1   = M_VLEAD;
					end else if (is_space(text_byte)) begin
						tne1 = pos;
						m1   = M_KEYGAP;
					end
				end
				M_KEYGAP: begin
					if (text_byte == CH_EQUALS) m1 = M_VLEAD;
				end
				M_VLEAD: begin
					if (is_newline(text_byte) || (text_byte == CH_SEMICOLON)) begin
						rk  = KIND_KEY;
						rns = tok_name_start;
						rne = tok_name_end;
						rvs = pos;
						rve = pos;
						m1  = (text_byte == CH_SEMICOLON) ? M_COMMENT : M_SKIP;
						n1  = 1'b1;
					end else if (!is_space(text_byte)) begin
						tvs1 = pos;
						lnp1 = pos + POS_ONE;
						m1   = M_VALUE;
					end
				end
				M_VALUE: begin
					if (is_newline(text_byte) || (text_byte == CH_SEMICOLON)) begin
						rk  = KIND_KEY;
						rns = tok_name_start;
						rne = tok_name_end;
						rvs = tok_value_start;
						rve = last_nonspace;
						m1  = (text_byte == CH_SEMICOLON) ? M_COMMENT : M_SKIP;
						n1  = 1'b1;
					end else if (!is_space(text_byte)) begin
						lnp1 = pos + POS_ONE;
					end
				end
				default: begin
					m1 = mode;
				end
			endcase
		end
	end

	// end of text, errors and the next state
	always_comb begin
		mode_nxt            = m1;
		pos_nxt             = pos1;
		section_seen_nxt    = ss1;
		entry_count_nxt     = n1 ? cnt_inc : entry_count;
		tok_name_start_nxt  = tns1;
		tok_name_end_nxt    = tne1;
		tok_value_start_nxt = tvs1;
		last_nonspace_nxt   = lnp1;
		emit                = 1'b0;
		rec.kind            = rk;
		ridx                = cnt_inc;
		rec.name_start      = 16'(rns);
		rec.name_end        = 16'(rne);
		rec.value_start     = 16'(rvs);
		rec.value_end       = 16'(rve);
		rfin                = 1'b0;
		clr                 = 1'b0;
		if (mode == M_DRAIN) begin
			mode_nxt            = mode;
			pos_nxt             = pos;
			section_seen_nxt    = section_seen;
			entry_count_nxt     = entry_count;
			tok_name_start_nxt  = tok_name_start;
			tok_name_end_nxt    = tok_name_end;
			tok_value_start_nxt = tok_value_start;
			last_nonspace_nxt   = last_nonspace;
			clr                 = term;
		end else if (err) begin
			emit            = 1'b1;
			rec.kind        = KIND_END_ERR;
			ridx            = entry_count;
			rec.name_start  = '0;
			rec.name_end    = '0;
			rec.value_start = '0;
			rec.value_end   = '0;
			rfin            = 1'b1;
			mode_nxt        = M_DRAIN;
			clr             = term;
		end else if (!term) begin
			emit = n1;
		end else begin
			emit = 1'b1;
			rfin = 1'b1;
			clr  = 1'b1;
			if (!n1) begin
				// close whatever token is still open at the end offset, or else send an end-ok record
				case (m1)
					M_SECTION: begin
						rec.kind        = KIND_SECTION;
						rec.name_start  = 16'(tns1);
						rec.name_end    = 16'(pos1);
						rec.value_start = '0;
						rec.value_end   = '0;
					end
					M_KEYNAME: begin
						rec.kind        = KIND_KEY;
						rec.name_start  = 16'(tns1);
						rec.name_end    = 16'(pos1);
						rec.value_start = 16'(pos1);
						rec.value_end   = 16'(pos1);
					end
					M_KEYGAP, M_VLEAD: begin
						rec.kind        = KIND_KEY;
						rec.name_start  = 16'(tns1);
						rec.name_end    = 16'(tne1);
						rec.value_start = 16'(pos1);
						rec.value_end   = 16'(pos1);
					end
					M_VALUE: begin
						rec.kind        = KIND_KEY;
						rec.name_start  = 16'(tns1);
						rec.name_end    = 16'(tne1);
						rec.value_start = 16'(tvs1);
						rec.value_end   = 16'(lnp1);
					end
					default: begin
						rec.kind        = KIND_END_OK;
						ridx            = entry_count;
						rec.name_start  = '0;
						rec.name_end    = '0;
						rec.value_start = '0;
						rec.value_end   = '0;
					end
				endcase
			end
		end
		rec.index      = ridx;
		rec.final_flag = rfin;
		if (clr) begin
			mode_nxt            = M_SKIP;
			pos_nxt             = '0;
			section_seen_nxt    = 1'b0;
			entry_count_nxt     = '0;
			tok_name_start_nxt  = '0;
			tok_name_end_nxt    = '0;
			tok_value_start_nxt = '0;
			last_nonspace_nxt   = '0;
		end
	end

endmodule

>>> sv/ini_text_tokenizer.sv
// channel  | handshake                  | word contents
// ---------+----------------------------+-------------------------------------------
// text     | text_valid / text_ready    | text_byte, last_byte
// record   | record_valid / record_ready| record_kind, entry_index, name and value
//          |                            | bounds, final_record
//
// one text byte per clock sustained while records are taken; a byte waits in the input register
// and its record (if any) is loaded into the output register when the byte advances
// state update and record forming sit in one combinational step between the two
// registers, so record_valid rises as the byte leaves the input register
// a record left untaken stalls the input register; text_ready drops only then
// arst_n clears the mode machine, offsets, counters and both valid flags
module ini_text_tokenizer #(
	parameter int OFFSET_BITS = 16
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        text_valid,
	output logic        text_ready,
	input  logic [7:0]  text_byte,
	input  logic        last_byte,
	output logic        record_valid,
	input  logic        record_ready,
	output logic [1:0]  record_kind,
	output logic [15:0] entry_index,
	output logic [15:0] name_start,
	output logic [15:0] name_end,
	output logic [15:0] value_start,
	output logic [15:0] value_end,
	output logic        final_record
);
	import itt_pkg::*;

	// input register
	logic       valid_s1;
	logic [7:0] byte_s1;
	logic       last_s1;

	// parser state
	mode_t                  mode_q;
	logic [OFFSET_BITS-1:0] pos_q;
	logic                   section_seen_q;
	logic [15:0]            entry_count_q;
	logic [OFFSET_BITS-1:0] tok_name_start_q;
	logic [OFFSET_BITS-1:0] tok_name_end_q;
	logic [OFFSET_BITS-1:0] tok_value_start_q;
	logic [OFFSET_BITS-1:0] last_nonspace_q;

	// next state from the step logic
	mode_t                  mode_nxt;
	logic [OFFSET_BITS-1:0] pos_nxt;
	logic                   section_seen_nxt;
	logic [15:0]            entry_count_nxt;
	logic [OFFSET_BITS-1:0] tok_name_start_nxt;
	logic [OFFSET_BITS-1:0] tok_name_end_nxt;
	logic [OFFSET_BITS-1:0] tok_value_start_nxt;
	logic [OFFSET_BITS-1:0] last_nonspace_nxt;
	logic                   emit;
	rec_t                   rec;

	// output register
	logic out_valid_q;
	rec_t rec_q;

	logic advance;

	// the byte in s1 moves on when the output register is free or being emptied
	assign advance    = valid_s1 && (!out_valid_q || record_ready);
	assign text_ready = !valid_s1 || advance;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (text_ready) begin
			valid_s1 <= text_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (text_ready && text_valid) begin
			byte_s1 <= text_byte;
			last_s1 <= last_byte;
		end
	end

	itt_step #(
		.OFFSET_BITS(OFFSET_BITS)
	) u_step (
		.mode               (mode_q),
		.pos                (pos_q),
		.section_seen       (section_seen_q),
		.entry_count        (entry_count_q),
		.tok_name_start     (tok_name_start_q),
		.tok_name_end       (tok_name_end_q),
		.tok_value_start    (tok_value_start_q),
		.last_nonspace      (last_nonspace_q),
		.text_byte          (byte_s1),
		.last_byte          (last_s1),
		.mode_nxt           (mode_nxt),
		.pos_nxt            (pos_nxt),
		.section_seen_nxt   (section_seen_nxt),
		.entry_count_nxt    (entry_count_nxt),
		.tok_name_start_nxt (tok_name_start_nxt),
		.tok_name_end_nxt   (tok_name_end_nxt),
		.tok_value_start_nxt(tok_value_start_nxt),
		.last_nonspace_nxt  (last_nonspace_nxt),
		.emit               (emit),
		.rec                (rec)
	);

	// parser state advances once per byte
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q            <= M_SKIP;
			pos_q             <= '0;
			section_seen_q    <= 1'b0;
			entry_count_q     <= '0;
			tok_name_start_q  <= '0;
			tok_name_end_q    <= '0;
			tok_value_start_q <= '0;
			last_nonspace_q   <= '0;
		end else if (advance) begin
			mode_q            <= mode_nxt;
			pos_q             <= pos_nxt;
			section_seen_q    <= section_seen_nxt;
			entry_count_q     <= entry_count_nxt;
			tok_name_start_q  <= tok_name_start_nxt;
			tok_name_end_q    <= tok_name_end_nxt;
			tok_value_start_q <= tok_value_start_nxt;
			last_nonspace_q   <= last_nonspace_nxt;
		end
	end

	// result register: loads a new word when empty or as the old one leaves
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (advance) begin
			out_valid_q <= emit;
		end else if (record_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (advance && emit) begin
			rec_q <= rec;
		end
	end

	assign record_valid = out_valid_q;
	assign record_kind  = rec_q.kind;
	assign entry_index  = rec_q.index;
	assign name_start   = rec_q.name_start;
	assign name_end     = rec_q.name_end;
	assign value_start  = rec_q.value_start;
	assign value_end    = rec_q.value_end;
	assign final_record = rec_q.final_flag;

	// an end record always closes the text
	assert property (@(posedge clk) disable iff (!arst_n)
		record_valid && ((record_kind == KIND_END_OK) || (record_kind == KIND_END_ERR))
		|-> final_record)
		else $error("end record without final flag");

	// nothing leaves while the rest of an errored text is being dropped
	assert property (@(posedge clk) disable iff (!arst_n)
		(mode_q == M_DRAIN) |-> !(advance && emit))
		else $error("record emitted while draining");

	// a key record only after some section
	assert property (@(posedge clk) disable iff (!arst_n)
		advance && emit && (rec.kind == KIND_KEY) |-> section_seen_q)
		else $error("key record before any section");

	// entry numbers count up by one for each non-final section or key
	assert property (@(posedge clk) disable iff (!arst_n)
		advance && emit && !rec.final_flag
		&& ((rec.kind == KIND_SECTION) || (rec.kind == KIND_KEY))
		|=> entry_count_q == $past(entry_count_q) + 16'd1)
		else $error("entry count did not step");

endmodule
